@@ sv/rau_pkg.sv @@
// shared constants, command codes and control/status types for the rational arithmetic unit
`timescale 1ns / 1ps

package rau_pkg;

	localparam int OPERAND_WIDTH_DEF = 32;
	localparam int FIELD_W           = 32;
	localparam int DEN_W             = 31;
	localparam int CMD_W             = 3;

	localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_SUB  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MUL  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DIV  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_NORM = 3'd4;

	typedef struct packed {
		logic load;
		logic mul1;
		logic mul2;
		logic mul3;
		logic form;
		logic gcd_step;
		logic gload;
		logic div_start;
		logic div_sel_d;
		logic wb_n;
		logic wb_d;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic gcd_done;
		logic g_zero;
		logic div_done;
	} ctl_sts_t;

endpackage

@@ sv/rau_req_if.sv @@
// request channel: command and two signed fractions
`timescale 1ns / 1ps

interface rau_req_if
	import rau_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic signed [FIELD_W-1:0] a_num;
	logic signed [FIELD_W-1:0] a_den;
	logic signed [FIELD_W-1:0] b_num;
	logic signed [FIELD_W-1:0] b_den;

	modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

@@ sv/rau_res_if.sv @@
// result channel: reduced fraction and flags
`timescale 1ns / 1ps

interface rau_res_if
	import rau_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [FIELD_W-1:0] res_num;
	logic [DEN_W-1:0]          res_den;
	logic                      zero_den;
	logic                      overflow;

	modport source (output valid, res_num, res_den, zero_den, overflow, input ready);
	modport sink (input valid, res_num, res_den, zero_den, overflow, output ready);
endinterface

@@ sv/rau_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps

module rau_div
	import rau_pkg::*;
#(
	parameter int WIDTH = 2 * OPERAND_WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] quotient,
	output logic             done
);

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   trial;

	// shifted partial remainder minus divisor, top bit set when it goes negative
	assign trial = {rem_q, quo_q[WIDTH-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(WIDTH - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!trial[WIDTH]) begin
				rem_q <= trial[WIDTH-1:0];
			end else begin
				rem_q <= {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
			end
			quo_q <= {quo_q[WIDTH-2:0], ~trial[WIDTH]};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

@@ sv/rau_dp.sv @@
// datapath: operand registers, shared multiplier, binary gcd, divider and output register
`timescale 1ns / 1ps

module rau_dp
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctl_cmd_t                  ctl,
	output ctl_sts_t                  sts,
	input  logic [CMD_W-1:0]          command,
	input  logic signed [FIELD_W-1:0] a_num,
	input  logic signed [FIELD_W-1:0] a_den,
	input  logic signed [FIELD_W-1:0] b_num,
	input  logic signed [FIELD_W-1:0] b_den,
	output logic signed [FIELD_W-1:0] res_num,
	output logic [DEN_W-1:0]          res_den,
	output logic                      zero_den,
	output logic                      overflow
);

	localparam int W  = OPERAND_WIDTH;
	localparam int W2 = 2 * OPERAND_WIDTH;
	localparam int KW = $clog2(W2);
	localparam logic [W2-1:0] HALF = W2'(1) << (W - 1);

	// sign bit on top, magnitude below
	function automatic logic [W:0] to_sm(input logic [FIELD_W-1:0] v);
		logic [W-1:0] f;
		f = v[W-1:0];
		return {f[W-1], f[W-1] ? (~f + W'(1)) : f};
	endfunction

	logic [CMD_W-1:0] cmd_q;
	logic [W-1:0]     an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic             an_s_q, ad_s_q, bn_s_q, bd_s_q;
	logic [W2-1:0]    t1_q, t2_q, t3_q;
	logic [W2-1:0]    nm_q, dm_q;
	logic             ns_q, ds_q;
	logic [W2-1:0]    x_q, y_q, g_q;
	logic [KW-1:0]    k_q;

	logic signed [FIELD_W-1:0] res_num_q;
	logic [DEN_W-1:0]          res_den_q;
	logic                      zero_den_q;
	logic                      ovf_q;

	logic          is_mul;
	logic          s1, s2;
	logic [W-1:0]  mul_a, mul_b;
	logic [W2-1:0] prod;
	logic [W2-1:0] add_m;
	logic          add_s;
	logic [W2-1:0] n_m, d_m;
	logic          n_s, d_s;
	logic [W2-1:0] quo;
	logic          div_done;
	logic          neg;
	logic          ovf;
	logic [W2-1:0] nb;
	logic signed [W-1:0] nb_w;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= command;
			{an_s_q, an_m_q} <= to_sm(a_num);
			{ad_s_q, ad_m_q} <= to_sm(a_den);
			{bn_s_q, bn_m_q} <= to_sm(b_num);
			{bd_s_q, bd_m_q} <= to_sm(b_den);
		end
	end

	assign is_mul = (cmd_q == CMD_MUL);
	assign s1 = an_s_q ^ (is_mul ? bn_s_q : bd_s_q);
	assign s2 = ad_s_q ^ (is_mul ? bd_s_q : bn_s_q) ^ (cmd_q == CMD_SUB);

	// one shared multiplier, one product per cycle
	always_comb begin
		if (ctl.mul1) begin
			mul_a = an_m_q;
			mul_b = is_mul ? bn_m_q : bd_m_q;
		end else if (ctl.mul2) begin
			mul_a = ad_m_q;
			mul_b = is_mul ? bd_m_q : bn_m_q;
		end else begin
			mul_a = ad_m_q;
			mul_b = bd_m_q;
		end
	end

	assign prod = W2'(mul_a) * W2'(mul_b);

	always_ff @(posedge clk) begin
		if (ctl.mul1) t1_q <= prod;
		if (ctl.mul2) t2_q <= prod;
		if (ctl.mul3) t3_q <= prod;
	end

	// sign-magnitude sum of the two numerator products
	always_comb begin
		if (s1 == s2) begin
			add_m = t1_q + t2_q;
			add_s = s1;
		end else if (t1_q >= t2_q) begin
			add_m = t1_q - t2_q;
			add_s = s1;
		end else begin
			add_m = t2_q - t1_q;
			add_s = s2;
		end
	end

	always_comb begin
		case (cmd_q)
			CMD_ADD, CMD_SUB: begin
				n_m = add_m;
				n_s = add_s;
				d_m = t3_q;
				d_s = ad_s_q ^ bd_s_q;
			end
			CMD_MUL, CMD_DIV: begin
				n_m = t1_q;
				n_s = s1;
				d_m = t2_q;
				d_s = s2;
			end
			default: begin
				n_m = W2'(an_m_q);
				n_s = an_s_q;
				d_m = W2'(ad_m_q);
				d_s = ad_s_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.form) begin
			nm_q <= n_m;
			ns_q <= n_s;
			dm_q <= d_m;
			ds_q <= d_s;
		end else if (ctl.wb_n) begin
			nm_q <= quo;
		end else if (ctl.wb_d) begin
			dm_q <= quo;
		end
	end

	// binary gcd: strip common twos, halve a lone even value, then subtract the smaller odd value from the larger
	always_ff @(posedge clk) begin
		if (ctl.form) begin
			x_q <= n_m;
			y_q <= d_m;
			k_q <= '0;
		end else if (ctl.gcd_step) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q >= y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.gload) begin
			g_q <= (x_q | y_q) << k_q;
		end
	end

	assign sts.gcd_done = (x_q == '0) || (y_q == '0);
	assign sts.g_zero   = ((x_q | y_q) == '0);
	assign sts.div_done = div_done;

	rau_div #(
		.WIDTH(W2)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (ctl.div_sel_d ? dm_q : nm_q),
		.divisor  (g_q),
		.quotient (quo),
		.done     (div_done)
	);

	// sign goes to the numerator; a zero denominator keeps the raw numerator sign
	assign neg  = (nm_q != '0) && ((dm_q != '0) ? (ns_q ^ ds_q) : ns_q);
	assign ovf  = (neg ? (nm_q > HALF) : (nm_q >= HALF)) || (dm_q >= HALF);
	assign nb   = neg ? (~nm_q + W2'(1)) : nm_q;
	assign nb_w = nb[W-1:0];

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			res_num_q  <= FIELD_W'(nb_w);
			res_den_q  <= DEN_W'(dm_q[W-2:0]);
			zero_den_q <= (dm_q == '0);
			ovf_q      <= ovf;
		end
	end

	assign res_num  = res_num_q;
	assign res_den  = res_den_q;
	assign zero_den = zero_den_q;
	assign overflow = ovf_q;

endmodule

@@ sv/rau_ctrl.sv @@
// controller: sequences multiply, reduce, divide and result handover
`timescale 1ns / 1ps

module rau_ctrl
	import rau_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     res_valid,
	input  logic     res_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t ctl
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_MUL1      = 4'd1;
	localparam logic [3:0] S_MUL2      = 4'd2;
	localparam logic [3:0] S_MUL3      = 4'd3;
	localparam logic [3:0] S_FORM      = 4'd4;
	localparam logic [3:0] S_GCD       = 4'd5;
	localparam logic [3:0] S_GLOAD     = 4'd6;
	localparam logic [3:0] S_DIVN_GO   = 4'd7;
	localparam logic [3:0] S_DIVN_WAIT = 4'd8;
	localparam logic [3:0] S_DIVD_GO   = 4'd9;
	localparam logic [3:0] S_DIVD_WAIT = 4'd10;
	localparam logic [3:0] S_FIN       = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = out_valid_q;
	assign out_free  = !out_valid_q || res_ready;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_MUL1;
				end
			end
			S_MUL1: begin
				ctl.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				ctl.mul2 = 1'b1;
				state_d  = S_MUL3;
			end
			S_MUL3: begin
				ctl.mul3 = 1'b1;
				state_d  = S_FORM;
			end
			S_FORM: begin
				ctl.form = 1'b1;
				state_d  = S_GCD;
			end
			S_GCD: begin
				if (!sts.gcd_done) begin
					ctl.gcd_step = 1'b1;
				end else if (sts.g_zero) begin
					// zero over zero passes through unreduced
					state_d = S_FIN;
				end else begin
					state_d = S_GLOAD;
				end
			end
			S_GLOAD: begin
				ctl.gload = 1'b1;
				state_d   = S_DIVN_GO;
			end
			S_DIVN_GO: begin
				ctl.div_start = 1'b1;
				state_d       = S_DIVN_WAIT;
			end
			S_DIVN_WAIT: begin
				if (sts.div_done) begin
					ctl.wb_n = 1'b1;
					state_d  = S_DIVD_GO;
				end
			end
			S_DIVD_GO: begin
				ctl.div_start = 1'b1;
				ctl.div_sel_d = 1'b1;
				state_d       = S_DIVD_WAIT;
			end
			S_DIVD_WAIT: begin
				ctl.div_sel_d = 1'b1;
				if (sts.div_done) begin
					ctl.wb_d = 1'b1;
					state_d  = S_FIN;
				end
			end
			S_FIN: begin
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/rational_arithmetic_unit.sv @@
// latency grows with the number of binary gcd steps and with the two bit-serial divisions
// zero over zero skips both divisions
// one request at a time, set by the gcd loop and the shared bit-serial divider
// the next request is taken while the previous result waits in the output register
// reset: arst_n clears the controller and the result valid; no memories to clear
`timescale 1ns / 1ps

module rational_arithmetic_unit
	import rau_pkg::*;
#(
	parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
	input logic    clk,
	input logic    arst_n,
	rau_req_if.sink   req,
	rau_res_if.source res
);

	ctl_cmd_t ctl;
	ctl_sts_t sts;
	logic     in_ready;
	logic     res_valid;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.res_valid (res_valid),
		.res_ready (res.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	rau_dp #(
		.OPERAND_WIDTH(OPERAND_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.command  (req.command),
		.a_num    (req.a_num),
		.a_den    (req.a_den),
		.b_num    (req.b_num),
		.b_den    (req.b_den),
		.res_num  (res.res_num),
		.res_den  (res.res_den),
		.zero_den (res.zero_den),
		.overflow (res.overflow)
	);

	assign req.ready = in_ready;
	assign res.valid = res_valid;

endmodule
